### sv/fdss_pkg.sv
// Package for fifo_dispatch_with_stay_stats: sizes, operation codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdss_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_SERVERS = 8;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W = 2;
  localparam int TIME_W = 32;
  localparam int ID_W = 16;
  localparam int IDLE_W = 8;
  localparam int SRV_W = 3;
  localparam int CNT_W = 32;
  localparam int SUM_W = 48;
  localparam int ENTRY_W = TIME_W + ID_W;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 208;

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVE = 2'd0,
    OP_DEPART = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

### sv/fdss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fdss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/fdss_ctrl.sv
// Controller for fifo_dispatch_with_stay_stats: sequences capture, load and commit.
// Depends on fdss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdss_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic             m_tready,
  input  wire fdss_pkg::status_t status,
  output fdss_pkg::cmd_t        cmd
);

  fdss_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      fdss_pkg::ST_IDLE: begin
        s_tready = !status.out_valid || m_tready;
        if (s_tvalid && s_tready) begin
          cmd.capture = 1'b1;
          state_next  = fdss_pkg::ST_LOAD;
        end
      end
      fdss_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = fdss_pkg::ST_COMMIT;
      end
      fdss_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = fdss_pkg::ST_IDLE;
      end
      default: begin
        state_next = fdss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/fdss_dp.sv
// Datapath for fifo_dispatch_with_stay_stats: queue memory, pointers,
// statistics registers and the result register.
// Depends on fdss_pkg and fdss_ram.
`timescale 1ns / 1ps
`default_nettype none

module fdss_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fdss_pkg::cmd_t                      cmd,
  output fdss_pkg::status_t                        status,
  input  wire logic [fdss_pkg::OP_W-1:0]           in_op,
  input  wire logic [fdss_pkg::S_TDATA_W-1:0]      in_data,
  input  wire logic                                m_tready,
  output logic [fdss_pkg::M_TDATA_W-1:0]           out_data
);

  logic [fdss_pkg::OP_W-1:0]   op_r;
  logic [fdss_pkg::TIME_W-1:0] now_r;
  logic [fdss_pkg::ID_W-1:0]   id_r;
  logic [fdss_pkg::IDLE_W-1:0] idle_r;

  logic [fdss_pkg::PTR_W-1:0]  head_ptr, tail_ptr;
  logic [fdss_pkg::OCC_W-1:0]  entry_count;
  logic [fdss_pkg::CNT_W-1:0]  crossings;
  logic [fdss_pkg::SUM_W-1:0]  stay_sum;
  logic [fdss_pkg::TIME_W-1:0] stay_max, stay_min;

  logic [fdss_pkg::TIME_W-1:0] stay_r;
  logic [fdss_pkg::ID_W-1:0]   head_id_r;
  logic                        found_r;
  logic [fdss_pkg::SRV_W-1:0]  srv_r;

  logic                        out_valid;
  logic [fdss_pkg::ENTRY_W-1:0] rd_entry;
  logic                        wr_en;

  logic                        found;
  logic [fdss_pkg::SRV_W-1:0]  srv;
  logic [fdss_pkg::SUM_W:0]    sum_ext;

  logic                        is_arrive, is_depart, is_clear;
  logic                        do_push, do_pop, drop;
  logic [fdss_pkg::PTR_W-1:0]  head_ptr_next, tail_ptr_next;
  logic [fdss_pkg::OCC_W-1:0]  entry_count_next;
  logic [fdss_pkg::CNT_W-1:0]  crossings_next;
  logic [fdss_pkg::SUM_W-1:0]  stay_sum_next;
  logic [fdss_pkg::TIME_W-1:0] stay_max_next, stay_min_next;

  assign status.out_valid = out_valid;

  // entry layout: id in the low bits, entry time above
  fdss_ram #(
    .WIDTH(fdss_pkg::ENTRY_W),
    .DEPTH(fdss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (wr_en),
    .waddr(tail_ptr),
    .wdata({now_r, id_r}),
    .raddr(head_ptr),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      now_r  <= in_data[fdss_pkg::TIME_W-1:0];
      id_r   <= in_data[fdss_pkg::TIME_W +: fdss_pkg::ID_W];
      idle_r <= in_data[fdss_pkg::TIME_W + fdss_pkg::ID_W +: fdss_pkg::IDLE_W];
    end
  end

  always_comb begin
    found = 1'b0;
    srv   = '0;
    for (int i = fdss_pkg::NUM_SERVERS - 1; i >= 0; i--) begin
      if (idle_r[i]) begin
        found = 1'b1;
        srv   = fdss_pkg::SRV_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stay_r    <= now_r - rd_entry[fdss_pkg::ID_W +: fdss_pkg::TIME_W];
      head_id_r <= rd_entry[fdss_pkg::ID_W-1:0];
      found_r   <= found;
      srv_r     <= srv;
    end
  end

  always_comb begin
    is_arrive = (op_r == fdss_pkg::OP_ARRIVE);
    is_depart = (op_r == fdss_pkg::OP_DEPART);
    is_clear  = (op_r == fdss_pkg::OP_CLEAR);

    do_push = is_arrive && !found_r
              && (entry_count < fdss_pkg::OCC_W'(fdss_pkg::QUEUE_DEPTH));
    drop    = is_arrive && !found_r
              && (entry_count >= fdss_pkg::OCC_W'(fdss_pkg::QUEUE_DEPTH));
    do_pop  = is_depart && (entry_count != '0);
    wr_en   = cmd.commit && do_push;

    sum_ext = {1'b0, stay_sum} + (fdss_pkg::SUM_W + 1)'(stay_r);

    head_ptr_next    = head_ptr;
    tail_ptr_next    = tail_ptr;
    entry_count_next = entry_count;
    crossings_next   = crossings;
    stay_sum_next    = stay_sum;
    stay_max_next    = stay_max;
    stay_min_next    = stay_min;

    if (is_clear) begin
      head_ptr_next    = '0;
      tail_ptr_next    = '0;
      entry_count_next = '0;
      crossings_next   = '0;
      stay_sum_next    = '0;
      stay_max_next    = '0;
      stay_min_next    = '1;
    end else begin
      if (is_arrive && crossings != '1) begin
        crossings_next = crossings + 1'b1;
      end
      if (is_arrive && found_r) begin
        stay_min_next = '0;
      end
      if (do_push) begin
        tail_ptr_next = (tail_ptr == fdss_pkg::PTR_W'(fdss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : tail_ptr + 1'b1;
        entry_count_next = entry_count + 1'b1;
      end
      if (do_pop) begin
        head_ptr_next = (head_ptr == fdss_pkg::PTR_W'(fdss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : head_ptr + 1'b1;
        entry_count_next = entry_count - 1'b1;
        stay_sum_next = sum_ext[fdss_pkg::SUM_W] ? '1 : sum_ext[fdss_pkg::SUM_W-1:0];
        if (stay_r > stay_max) begin
          stay_max_next = stay_r;
        end
        if (stay_r < stay_min) begin
          stay_min_next = stay_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr    <= '0;
      tail_ptr    <= '0;
      entry_count <= '0;
      crossings   <= '0;
      stay_sum    <= '0;
      stay_max    <= '0;
      stay_min    <= '1;
    end else if (cmd.commit) begin
      head_ptr    <= head_ptr_next;
      tail_ptr    <= tail_ptr_next;
      entry_count <= entry_count_next;
      crossings   <= crossings_next;
      stay_sum    <= stay_sum_next;
      stay_max    <= stay_max_next;
      stay_min    <= stay_min_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {
        2'b00,
        drop,
        stay_min_next,
        stay_max_next,
        stay_sum_next,
        crossings_next,
        entry_count_next,
        (entry_count_next == '0),
        do_pop ? stay_r : '0,
        (is_arrive && found_r) ? id_r : (do_pop ? head_id_r : '0),
        do_pop,
        (is_arrive && found_r) ? srv_r : '0,
        is_arrive && found_r
      };
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= fdss_pkg::OCC_W'(fdss_pkg::QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> entry_count < fdss_pkg::OCC_W'(fdss_pkg::QUEUE_DEPTH))
    else $error("write into a full queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    entry_count == '0 |-> head_ptr == tail_ptr)
    else $error("empty queue with unequal pointers");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    stay_max >= stay_min || stay_min == '1)
    else $error("minimum stay above maximum stay");

endmodule

`default_nettype wire

### sv/fifo_dispatch_with_stay_stats.sv
// Each request passes through accept, queue memory read and stay subtraction,
// then commit into the statistics and the result register; the registered
// read of the queue memory makes the read a step of its own. A new request is
// accepted once the previous result has been taken or is taken in that same
// cycle, so a result waiting at the output holds the input back until it goes.
// Depends on fdss_pkg, fdss_ctrl, fdss_dp and fdss_ram.
`timescale 1ns / 1ps
`default_nettype none

module fifo_dispatch_with_stay_stats (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // now_time[31:0], entity_id[47:32], server_idle[55:48]
  input  wire logic [fdss_pkg::S_TDATA_W-1:0] s_tdata,
  // op[1:0]
  input  wire logic [fdss_pkg::OP_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // dispatched[0], server_index[3:1], released[4], entity_out[20:5],
  // stay_time[52:21], queue_empty[53], occupancy[60:54], crossed_count[92:61],
  // total_stay[140:93], max_stay[172:141], min_stay[204:173],
  // queue_full_drop[205], zero fill [207:206]
  output logic [fdss_pkg::M_TDATA_W-1:0]      m_tdata
);

  fdss_pkg::cmd_t    cmd;
  fdss_pkg::status_t status;

  fdss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tready(m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  fdss_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_op   (s_tuser),
    .in_data (s_tdata),
    .m_tready(m_tready),
    .out_data(m_tdata)
  );

  assign m_tvalid = status.out_valid;

endmodule

`default_nettype wire
